### sv/hslrgb_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hslrgb_pkg
// Shared field widths, fixed-point defaults and sextant codes for the
// HSL to RGB colour converter.
// ---------------------------------------------------------------------------
package hslrgb_pkg;

    localparam int FRAC_BITS_DEF = 12;

    localparam int HUE_W = 12;
    localparam int SAT_W = 13;
    localparam int LIG_W = 14;
    localparam int CH_W  = 8;

    // packed stream widths, padded to whole bytes
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

    // hue sextant: dominant channel first, then the one on the ramp
    typedef enum logic [2:0] {
        SX_RG = 3'd0,
        SX_GR = 3'd1,
        SX_GB = 3'd2,
        SX_BG = 3'd3,
        SX_BR = 3'd4,
        SX_RB = 3'd5
    } sext_t;

    localparam logic [7:0] SEXT_LAST = 8'd5;

endpackage : hslrgb_pkg
`default_nettype wire

### sv/hslrgb_chroma.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hslrgb_chroma
// Three stages: condition the inputs and split the hue, form the chroma
// top from lightness and saturation, then the floor, the span and the grey decision.
// ---------------------------------------------------------------------------
module hslrgb_chroma
    import hslrgb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [HUE_W-1:0]        hue,
    input  wire logic [SAT_W-1:0]        saturation,
    input  wire logic signed [LIG_W-1:0] lightness,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [FRAC_BITS+1:0]         top,
    output logic [FRAC_BITS+1:0]         floor_val,
    output logic [FRAC_BITS+1:0]         span,
    output logic [FRAC_BITS:0]           grey,
    output logic [FRAC_BITS-1:0]         frac,
    output logic [2:0]                   sext,
    output logic                         grey_sel
);

    localparam int LW  = FRAC_BITS + 1;
    localparam int VW  = FRAC_BITS + 2;
    localparam int CW  = (LW > LIG_W) ? LW : LIG_W;
    localparam int H6W = HUE_W + 3;
    localparam int SXW = (H6W > FRAC_BITS) ? (H6W - FRAC_BITS) : 1;
    localparam int XW  = FRAC_BITS + SXW;

    localparam logic [CW-1:0] ONE_C  = CW'(1) << FRAC_BITS;
    localparam logic [LW-1:0] ONE_L  = LW'(1) << FRAC_BITS;
    localparam logic [LW-1:0] HALF_L = LW'(1) << (FRAC_BITS - 1);

    logic rdy1, rdy2, rdy3;
    logic v1_reg, v2_reg, v3_reg;

    // stage 1: magnitude, clamp, hue times six
    logic [LIG_W-1:0]     mag;
    logic [CW-1:0]        mag_ext;
    logic [CW-1:0]        sat_ext;
    logic [XW-1:0]        h6;
    logic [LW-1:0]        l1_next, s1_next;
    logic [LW-1:0]        l1_reg, s1_reg;
    logic [SXW-1:0]       sx1_reg;
    logic [FRAC_BITS-1:0] fr1_reg;

    always_comb
    begin
        mag     = lightness[LIG_W-1] ? (LIG_W'(0) - lightness) : lightness;
        mag_ext = CW'(mag);
        sat_ext = CW'(saturation);
        l1_next = (mag_ext > ONE_C) ? ONE_L : LW'(mag_ext);
        s1_next = (sat_ext > ONE_C) ? ONE_L : LW'(sat_ext);
        h6      = (XW'(hue) << 2) + (XW'(hue) << 1);
    end

    assign rdy1 = !v1_reg || rdy2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (rdy1)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            l1_reg  <= l1_next;
            s1_reg  <= s1_next;
            sx1_reg <= h6[FRAC_BITS +: SXW];
            fr1_reg <= h6[FRAC_BITS-1:0];
        end
    end

    // stage 2: chroma top
    logic [2*LW-1:0]      ls_prod;
    logic [LW-1:0]        ls;
    logic [VW-1:0]        v2_next;
    logic [VW-1:0]        v2_val_reg;
    logic [LW-1:0]        l2_reg;
    logic [SXW-1:0]       sx2_reg;
    logic [FRAC_BITS-1:0] fr2_reg;

    always_comb
    begin
        ls_prod = l1_reg * s1_reg;
        ls      = ls_prod[FRAC_BITS +: LW];
        if (l1_reg <= HALF_L)
            v2_next = VW'(l1_reg) + VW'(ls);
        else
            v2_next = VW'(l1_reg) + VW'(s1_reg) - VW'(ls);
    end

    assign rdy2 = !v2_reg || rdy3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (rdy2)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            v2_val_reg <= v2_next;
            l2_reg     <= l1_reg;
            sx2_reg    <= sx1_reg;
            fr2_reg    <= fr1_reg;
        end
    end

    // stage 3: floor, span and the grey decision
    logic [VW-1:0]        m3_next, d3_next;
    logic [7:0]           sx_wide;
    logic                 g3_next;
    logic [VW-1:0]        v3_val_reg, m3_reg, d3_reg;
    logic [LW-1:0]        l3_reg;
    logic [FRAC_BITS-1:0] fr3_reg;
    logic [2:0]           sx3_reg;
    logic                 g3_reg;

    always_comb
    begin
        m3_next = {l2_reg, 1'b0} - v2_val_reg;
        d3_next = v2_val_reg - m3_next;
        sx_wide = 8'(sx2_reg);
        g3_next = (v2_val_reg == '0) || (sx_wide > SEXT_LAST);
    end

    assign rdy3 = !v3_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (rdy3)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            v3_val_reg <= v2_val_reg;
            m3_reg     <= m3_next;
            d3_reg     <= d3_next;
            l3_reg     <= l2_reg;
            fr3_reg    <= fr2_reg;
            sx3_reg    <= sx_wide[2:0];
            g3_reg     <= g3_next;
        end
    end

    assign in_ready  = rdy1;
    assign out_valid = v3_reg;
    assign top       = v3_val_reg;
    assign floor_val = m3_reg;
    assign span      = d3_reg;
    assign grey      = l3_reg;
    assign frac      = fr3_reg;
    assign sext      = sx3_reg;
    assign grey_sel  = g3_reg;

endmodule : hslrgb_chroma
`default_nettype wire

### sv/hslrgb_ramp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hslrgb_ramp
// Two stages: scale the span by the hue fraction, then build the rising
// and falling values and route them to the channels by sextant.
// ---------------------------------------------------------------------------
module hslrgb_ramp
    import hslrgb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [FRAC_BITS+1:0] top,
    input  wire logic [FRAC_BITS+1:0] floor_val,
    input  wire logic [FRAC_BITS+1:0] span,
    input  wire logic [FRAC_BITS:0]   grey,
    input  wire logic [FRAC_BITS-1:0] frac,
    input  wire logic [2:0]           sext,
    input  wire logic                 grey_sel,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [FRAC_BITS+1:0]      red_lin,
    output logic [FRAC_BITS+1:0]      green_lin,
    output logic [FRAC_BITS+1:0]      blue_lin
);

    localparam int LW = FRAC_BITS + 1;
    localparam int VW = FRAC_BITS + 2;
    localparam int PW = VW + FRAC_BITS;

    logic rdy4, rdy5;
    logic v4_reg, v5_reg;

    // stage 4: ramp step
    logic [PW-1:0] vs_prod;
    logic [VW-1:0] vs4_reg, t4_reg, m4_reg;
    logic [LW-1:0] l4_reg;
    logic [2:0]    sx4_reg;
    logic          g4_reg;

    assign vs_prod = PW'(span) * PW'(frac);
    assign rdy4    = !v4_reg || rdy5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (rdy4)
            v4_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && in_valid)
        begin
            vs4_reg <= vs_prod[FRAC_BITS +: VW];
            t4_reg  <= top;
            m4_reg  <= floor_val;
            l4_reg  <= grey;
            sx4_reg <= sext;
            g4_reg  <= grey_sel;
        end
    end

    // stage 5: channel routing
    logic [VW-1:0] rise, fall, gl;
    logic [VW-1:0] r_next, g_next, b_next;
    logic [VW-1:0] r5_reg, g5_reg, b5_reg;

    always_comb
    begin
        rise   = m4_reg + vs4_reg;
        fall   = t4_reg - vs4_reg;
        gl     = VW'(l4_reg);
        r_next = gl;
        g_next = gl;
        b_next = gl;
        if (!g4_reg)
        begin
            case (sext_t'(sx4_reg))
                SX_RG:
                begin
                    r_next = t4_reg; g_next = rise;   b_next = m4_reg;
                end
                SX_GR:
                begin
                    r_next = fall;   g_next = t4_reg; b_next = m4_reg;
                end
                SX_GB:
                begin
                    r_next = m4_reg; g_next = t4_reg; b_next = rise;
                end
                SX_BG:
                begin
                    r_next = m4_reg; g_next = fall;   b_next = t4_reg;
                end
                SX_BR:
                begin
                    r_next = rise;   g_next = m4_reg; b_next = t4_reg;
                end
                SX_RB:
                begin
                    r_next = t4_reg; g_next = m4_reg; b_next = fall;
                end
                default:
                begin
                    r_next = gl; g_next = gl; b_next = gl;
                end
            endcase
        end
    end

    assign rdy5 = !v5_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (rdy5)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy5 && v4_reg)
        begin
            r5_reg <= r_next;
            g5_reg <= g_next;
            b5_reg <= b_next;
        end
    end

    assign in_ready  = rdy4;
    assign out_valid = v5_reg;
    assign red_lin   = r5_reg;
    assign green_lin = g5_reg;
    assign blue_lin  = b5_reg;

endmodule : hslrgb_ramp
`default_nettype wire

### sv/hslrgb_scale.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hslrgb_scale
// Output stage: scale each unit channel by 255, truncate and clamp to a byte and
// hold the result until the sink takes it.
// ---------------------------------------------------------------------------
module hslrgb_scale
    import hslrgb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [FRAC_BITS+1:0] red_lin,
    input  wire logic [FRAC_BITS+1:0] green_lin,
    input  wire logic [FRAC_BITS+1:0] blue_lin,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [CH_W-1:0]           red,
    output logic [CH_W-1:0]           green,
    output logic [CH_W-1:0]           blue
);

    localparam int VW = FRAC_BITS + 2;
    localparam int PW = VW + CH_W;
    localparam int YW = PW - FRAC_BITS;

    function automatic logic [CH_W-1:0] to_byte(input logic [VW-1:0] x);
        logic [PW-1:0] p;
        logic [YW-1:0] y;
        // x*255 as x*256 - x
        p = {x, {CH_W{1'b0}}} - PW'(x);
        y = p[PW-1:FRAC_BITS];
        return (|y[YW-1:CH_W]) ? CH_MAX : y[CH_W-1:0];
    endfunction

    logic            v6_reg;
    logic [CH_W-1:0] r6_reg, g6_reg, b6_reg;

    assign in_ready = !v6_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (in_ready)
            v6_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            r6_reg <= to_byte(red_lin);
            g6_reg <= to_byte(green_lin);
            b6_reg <= to_byte(blue_lin);
        end
    end

    assign out_valid = v6_reg;
    assign red       = r6_reg;
    assign green     = g6_reg;
    assign blue      = b6_reg;

endmodule : hslrgb_scale
`default_nettype wire

### sv/hsl_to_rgb_convert.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hsl_to_rgb_convert
// Fixed-point HSL to 8-bit RGB colour conversion, one pixel per clock while the sink is ready.
// ---------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  hue, saturation, lightness
//  m_axis    out        m_axis_tvalid/m_axis_tready  red, green, blue
//
//  One transaction in and one out per clock while the sink is ready; there is one
//  register stage each for clamp, chroma, floor, ramp, routing and byte scale.
//  Each stage carries its own valid bit and fills whenever it is empty or
//  its successor moves, so bubbles close up under a stalled sink.
//  rst_n clears the valid bits only; the data registers are not reset.
// ---------------------------------------------------------------------------
module hsl_to_rgb_convert
    import hslrgb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [11:0] hue, [24:12] saturation, [38:25] lightness, [39] zero
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    logic                 c_valid, c_ready;
    logic [FRAC_BITS+1:0] top, floor_val, span;
    logic [FRAC_BITS:0]   grey;
    logic [FRAC_BITS-1:0] frac;
    logic [2:0]           sext;
    logic                 grey_sel;

    logic                 r_valid, r_ready;
    logic [FRAC_BITS+1:0] red_lin, green_lin, blue_lin;

    logic [CH_W-1:0]      red, green, blue;

    hslrgb_chroma #(.FRAC_BITS(FRAC_BITS)) u_chroma
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .hue        (s_axis_tdata[HUE_W-1:0]),
        .saturation (s_axis_tdata[HUE_W +: SAT_W]),
        .lightness  (s_axis_tdata[HUE_W+SAT_W +: LIG_W]),
        .out_valid  (c_valid),
        .out_ready  (c_ready),
        .top        (top),
        .floor_val  (floor_val),
        .span       (span),
        .grey       (grey),
        .frac       (frac),
        .sext       (sext),
        .grey_sel   (grey_sel)
    );

    hslrgb_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (c_valid),
        .in_ready   (c_ready),
        .top        (top),
        .floor_val  (floor_val),
        .span       (span),
        .grey       (grey),
        .frac       (frac),
        .sext       (sext),
        .grey_sel   (grey_sel),
        .out_valid  (r_valid),
        .out_ready  (r_ready),
        .red_lin    (red_lin),
        .green_lin  (green_lin),
        .blue_lin   (blue_lin)
    );

    hslrgb_scale #(.FRAC_BITS(FRAC_BITS)) u_scale
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (r_valid),
        .in_ready   (r_ready),
        .red_lin    (red_lin),
        .green_lin  (green_lin),
        .blue_lin   (blue_lin),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    assign m_axis_tdata = {blue, green, red};

endmodule : hsl_to_rgb_convert
`default_nettype wire

### tb/hsl_to_rgb_convert_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// hsl_to_rgb_convert_test
// Streams HSL pixels through the converter under random source gaps and
// sink stalls. A checker class works out the RGB value of every accepted
// pixel and compares each output transaction against the oldest one due.
// ---------------------------------------------------------------------------
module hsl_to_rgb_convert_test;
    import hslrgb_pkg::*;

    // red sits in the low byte, as on m_axis_tdata
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } rgb_t;

    class rgb_checker;
        rgb_t rgb_due_q[$];
        int   mismatch_count;

        function logic [CH_W-1:0] to_byte(longint unsigned x);
            longint unsigned y;
            y = (x * 255) >> FRAC_BITS_DEF;
            return (y > CH_MAX) ? CH_MAX : y[CH_W-1:0];
        endfunction

        function rgb_t hsl_to_rgb(logic [HUE_W-1:0] hue, logic [SAT_W-1:0] sat,
                                  logic [LIG_W-1:0] lig);
            longint unsigned one, s, l, ls, v, m, h6, frac, vs, c1, c2, r, g, b;
            rgb_t px;
            one = 64'd1 << FRAC_BITS_DEF;
            s   = sat;
            l   = lig[LIG_W-1] ? (64'd1 << LIG_W) - lig : lig;
            if (l > one)
                l = one;
            if (s > one)
                s = one;
            r = l;
            g = l;
            b = l;
            ls = (l * s) >> FRAC_BITS_DEF;
            v  = (l <= (one >> 1)) ? l + ls : l + s - ls;
            h6 = hue * 6;
            // zero chroma top, or a sextant out of range: leave it grey
            if (v != 0 && (h6 >> FRAC_BITS_DEF) <= SEXT_LAST)
            begin
                m    = l + l - v;
                frac = h6 & (one - 1);
                vs   = ((v - m) * frac) >> FRAC_BITS_DEF;
                c1   = m + vs;
                c2   = v - vs;
                case (sext_t'(h6 >> FRAC_BITS_DEF))
                    SX_RG: begin r = v;  g = c1; b = m;  end
                    SX_GR: begin r = c2; g = v;  b = m;  end
                    SX_GB: begin r = m;  g = v;  b = c1; end
                    SX_BG: begin r = m;  g = c2; b = v;  end
                    SX_BR: begin r = c1; g = m;  b = v;  end
                    SX_RB: begin r = v;  g = m;  b = c2; end
                    default: ;
                endcase
            end
            px.red   = to_byte(r);
            px.green = to_byte(g);
            px.blue  = to_byte(b);
            return px;
        endfunction

        task flag_mismatch(string msg);
            $display("ERROR at %0t ns: %s", $time, msg);
            mismatch_count++;
        endtask

        function void note_pixel(logic [HUE_W-1:0] hue, logic [SAT_W-1:0] sat,
                                 logic [LIG_W-1:0] lig);
            rgb_due_q.push_back(hsl_to_rgb(hue, sat, lig));
        endfunction

        function int pixels_due();
            return rgb_due_q.size();
        endfunction

        task check_pixel(logic [OUT_DATA_W-1:0] data);
            rgb_t got;
            rgb_t want;
            got = rgb_t'(data);
            if (rgb_due_q.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected pixel %h", data));
                return;
            end
            want = rgb_due_q.pop_front();
            if (got.red !== want.red)
                flag_mismatch($sformatf("red %h, want %h", got.red, want.red));
            if (got.green !== want.green)
                flag_mismatch($sformatf("green %h, want %h", got.green, want.green));
            if (got.blue !== want.blue)
                flag_mismatch($sformatf("blue %h, want %h", got.blue, want.blue));
        endtask
    endclass

    localparam int N_DIRECTED = 20;
    localparam int N_RANDOM   = 1880;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    rgb_checker board = new();
    int         pixels_sent = 0;
    bit         gaps_off    = 1'b0;
    bit         hold_sink   = 1'b0;

    // sextant edges, saturation and lightness at and beyond one, zero lightness
    int d_hue[N_DIRECTED] = '{0, 4095, 0, 683, 1366, 2048, 2731, 3414, 682, 1365,
                              2047, 2730, 3413, 4095, 100, 3000, 500, 1000, 4095, 2000};
    int d_sat[N_DIRECTED] = '{0, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 8191,
                              2048, 4096, 6000, 4096, 0, 4096, 1, 4097, 8191, 3000};
    int d_lig[N_DIRECTED] = '{0, 4096, 2048, 2048, 2048, 2048, 2048, 2048, 2049, 1000,
                              -2048, -4096, -8192, 8191, 3000, 1, -1, 4097, -8191, 2048};
    int edge_sat[7]  = '{0, 1, 2048, 4095, 4096, 4097, 8191};
    int edge_lig[11] = '{0, 1, 2047, 2048, 2049, 4095, 4096, -4096, -1, -8192, 8191};

    hsl_to_rgb_convert u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 clk = ~clk;

    task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [SAT_W-1:0] sat,
                              input logic [LIG_W-1:0] lig);
        if (!gaps_off && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, lig, sat, hue};
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_pixel(hue, sat, lig);
        pixels_sent++;
    endtask

    task automatic send_random_pixel();
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] sat;
        logic [LIG_W-1:0] lig;
        hue = HUE_W'($urandom);
        case ($urandom_range(0, 9))
            6, 7:
            begin
                sat = SAT_W'($urandom);
                lig = LIG_W'($urandom);
            end
            8:
            begin
                sat = SAT_W'(edge_sat[$urandom_range(0, 6)]);
                lig = LIG_W'(edge_lig[$urandom_range(0, 10)]);
            end
            9:
            begin
                sat = SAT_W'($urandom_range(0, 4096));
                lig = LIG_W'(int'($urandom_range(0, 128)) - 64);
            end
            default:
            begin
                sat = SAT_W'($urandom_range(0, 4096));
                lig = LIG_W'(int'($urandom_range(0, 8192)) - 4096);
            end
        endcase
        send_pixel(hue, sat, lig);
    endtask

    // source
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int k = 0; k < N_DIRECTED; k++)
            send_pixel(HUE_W'(d_hue[k]), SAT_W'(d_sat[k]), LIG_W'(d_lig[k]));
        for (int i = 0; i < N_RANDOM; i++)
        begin
            // gap-free stretches now and then, and no gaps or stalls at all in the tail
            gaps_off = (i % 300 >= 220) || (i >= N_RANDOM - 280);
            if (i == 900)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (board.pixels_due() != 0)
                    @(posedge clk);
            end
            send_random_pixel();
        end
        s_axis_tvalid <= 1'b0;
        while (board.pixels_due() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // sink: check each output transaction, then pick next cycle's ready
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                board.check_pixel(m_axis_tdata);
            if (hold_sink)
                m_axis_tready <= 1'b0;
            else if (gaps_off)
            begin
                stall_left = 0;
                m_axis_tready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left = int'($urandom_range(1, 15)) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // hold the sink off long enough for the pipeline to fill and block its input
    initial
    begin
        wait (pixels_sent >= 400);
        @(posedge clk);
        hold_sink <= 1'b1;
        repeat (80) @(posedge clk);
        hold_sink <= 1'b0;
    end

    initial
    begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
sv/hslrgb_pkg.sv
sv/hslrgb_chroma.sv
sv/hslrgb_ramp.sv
sv/hslrgb_scale.sv
sv/hsl_to_rgb_convert.sv
tb/hsl_to_rgb_convert_test.sv
